@@ sv/mts_pkg.sv @@
`default_nettype none
package mts_pkg;

	localparam int DataWidth = 32;
	localparam int OccWidth  = 9;
	localparam int StatWidth = 2;

	typedef logic signed [DataWidth-1:0] data_t;
	typedef logic [StatWidth-1:0]        status_t;

	localparam logic    OP_PUSH = 1'b0;
	localparam logic    OP_POP  = 1'b1;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_UNDERFLOW = 2'd1;
	localparam status_t ST_OVERFLOW  = 2'd2;

endpackage
`default_nettype wire

@@ sv/max_tracking_stack_core.sv @@
`default_nettype none
// Order: a command transferred at a rising edge is first registered as pending (busy high),
//   and its result is then registered with done high.
// Throughput: no new command is taken while one is pending, set by the registered read of the value and
//   maximum memories on the pop path; busy is high for the one cycle in between.
// Reset clears the entry count, the running maximum and the strobe; the memories are not
//   cleared. The receiver cannot stall: each result is shown for exactly one cycle.
module max_tracking_stack_core #(
	parameter int STACK_DEPTH = 256
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire                   opcode,
	input  wire mts_pkg::data_t   push_value,
	output logic                  done,
	output mts_pkg::data_t        popped_value,
	output mts_pkg::data_t        highest,
	output logic [8:0]            occupancy,
	output logic                  is_empty,
	output mts_pkg::status_t      status
);
	import mts_pkg::*;

	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int OW = (PW > OccWidth) ? PW : OccWidth;
	localparam logic [PW-1:0] FullCount = PW'(STACK_DEPTH);

	data_t value_mem [STACK_DEPTH];
	data_t max_mem   [STACK_DEPTH];

	logic [PW-1:0] ptr_q;
	data_t         cur_max_q;
	logic          pend_q;
	logic          pend_op_q;
	status_t       pend_status_q;
	data_t         rd_val_q;
	data_t         rd_max_q;

	logic          accept;
	logic          is_full;
	logic          is_zero;
	logic [PW-1:0] ptr_m1;
	logic [PW-1:0] ptr_m2;
	data_t         push_max;
	logic          wr_en;
	data_t         pop_max;
	logic [OW-1:0] occ_w;

	assign accept  = start && !pend_q;
	assign busy    = pend_q;
	assign is_full = (ptr_q == FullCount);
	assign is_zero = (ptr_q == '0);
	assign ptr_m1  = ptr_q - PW'(1);
	assign ptr_m2  = ptr_q - PW'(2);
	assign wr_en   = accept && (opcode == OP_PUSH) && !is_full;
	assign occ_w   = OW'(ptr_q);

	// new maximum: the value itself on an empty stack, else the larger of the two
	always_comb begin
		if (is_zero || (push_value > cur_max_q)) begin
			push_max = push_value;
		end else begin
			push_max = cur_max_q;
		end
	end

	// ptr_q already holds the count after the pop when the read data is used
	assign pop_max = is_zero ? '0 : rd_max_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			value_mem[ptr_q[AW-1:0]] <= push_value;
			max_mem[ptr_q[AW-1:0]]   <= push_max;
		end
	end

	// read the top entry's value and the maximum stored with the entry below it on every cycle
	always_ff @(posedge clk) begin
		rd_val_q <= value_mem[ptr_m1[AW-1:0]];
		rd_max_q <= max_mem[ptr_m2[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q         <= '0;
			cur_max_q     <= '0;
			pend_q        <= 1'b0;
			pend_op_q     <= OP_PUSH;
			pend_status_q <= ST_OK;
			done          <= 1'b0;
		end else begin
			done <= pend_q;
			if (accept) begin
				pend_q    <= 1'b1;
				pend_op_q <= opcode;
				unique case (opcode)
					OP_PUSH: begin
						if (is_full) begin
							pend_status_q <= ST_OVERFLOW;
						end else begin
							pend_status_q <= ST_OK;
							ptr_q         <= ptr_q + PW'(1);
							cur_max_q     <= push_max;
						end
					end
					OP_POP: begin
						if (is_zero) begin
							pend_status_q <= ST_UNDERFLOW;
						end else begin
							pend_status_q <= ST_OK;
							ptr_q         <= ptr_m1;
						end
					end
					default: pend_status_q <= ST_OK;
				endcase
			end else if (pend_q) begin
				pend_q <= 1'b0;
				if (pend_op_q == OP_POP && pend_status_q == ST_OK) begin
					cur_max_q <= pop_max;
				end
			end
		end
	end

	// result registers carry payload only
	always_ff @(posedge clk) begin
		if (pend_q) begin
			occupancy <= occ_w[OccWidth-1:0];
			is_empty  <= is_zero;
			status    <= pend_status_q;
			if (pend_op_q == OP_POP && pend_status_q == ST_OK) begin
				popped_value <= rd_val_q;
				highest      <= pop_max;
			end else begin
				popped_value <= '0;
				highest      <= cur_max_q;
			end
		end
	end

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= FullCount)
		else $error("entry count beyond stack depth");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("result strobe missing after transfer");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("busy not raised after transfer");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_UNDERFLOW) |-> (is_empty && highest == '0 && popped_value == '0))
		else $error("underflow result not empty");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OVERFLOW) |-> (is_full && popped_value == '0))
		else $error("overflow reported on a stack that is not full");

endmodule
`default_nettype wire
